// ===== hdl/butterworth_lowpass_freq_weight_unit_defines.svh =====
// assertion macros for the butterworth frequency weighting unit
// no dependencies; included by files that carry concurrent assertions
`ifndef BUTTERWORTH_LOWPASS_FREQ_WEIGHT_UNIT_DEFINES_SVH
`define BUTTERWORTH_LOWPASS_FREQ_WEIGHT_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BLFW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("blfw assertion failed");

// next-cycle implication, disabled during reset
`define BLFW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("blfw assertion failed");

`endif

// ===== hdl/blfw_pkg.sv =====
// shared types, constants and register codes of the weighting unit
// no dependencies
package blfw_pkg;

    localparam int IDX_W      = 10;
    localparam int TM_W       = 11;
    localparam int NORM_W     = 24;
    localparam int ORDER_W    = 4;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int T_W        = TM_W + NORM_W;
    localparam int SQ_W       = 48;
    localparam int W_W        = 16;
    localparam int POW_STAGES = (1 << ORDER_W) - 1;
    localparam int DIV_STAGES = W_W;
    localparam int MAX_DIM_DEF = 1024;

    localparam logic [DATA_W:0]  DIV_NUM = {1'b1, {DATA_W{1'b0}}};
    localparam logic [DATA_W-1:0] ONE_Q16 = 32'd65536;
    localparam logic [W_W-1:0]   W_MAX   = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TWICE_MID_X  = 3'd0,
        REG_TWICE_MID_Y  = 3'd1,
        REG_TWICE_MID_Z  = 3'd2,
        REG_NORM_X       = 3'd3,
        REG_NORM_Y       = 3'd4,
        REG_NORM_Z       = 3'd5,
        REG_FILTER_ORDER = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [TM_W-1:0]    tm_x;
        logic [TM_W-1:0]    tm_y;
        logic [TM_W-1:0]    tm_z;
        logic [NORM_W-1:0]  norm_x;
        logic [NORM_W-1:0]  norm_y;
        logic [NORM_W-1:0]  norm_z;
        logic [ORDER_W-1:0] order;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        tm_x: 11'd1024, tm_y: 11'd1024, tm_z: 11'd1,
        norm_x: '0, norm_y: '0, norm_z: '0, order: 4'd1
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic valid;
        logic sat;
    } pipe_ctl_t;

endpackage

// ===== hdl/blfw_in_if.sv =====
// request channel carrying one indexed frequency sample
// depends on blfw_pkg
interface blfw_in_if;
    import blfw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         x_index;
    logic [IDX_W-1:0]         y_index;
    logic [IDX_W-1:0]         z_index;
    logic signed [DATA_W-1:0] real_in;
    logic signed [DATA_W-1:0] imag_in;

    modport source (output valid, x_index, y_index, z_index, real_in, imag_in,
                    input ready);
    modport sink   (input valid, x_index, y_index, z_index, real_in, imag_in,
                    output ready);
endinterface

// ===== hdl/blfw_out_if.sv =====
// result channel carrying one weighted complex sample
// depends on blfw_pkg
interface blfw_out_if;
    import blfw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] real_out;
    logic signed [DATA_W-1:0] imag_out;

    modport source (output valid, real_out, imag_out, input ready);
    modport sink   (input valid, real_out, imag_out, output ready);
endinterface

// ===== hdl/blfw_dist.sv =====
// clamp, fold, scale, square and sum of the three axis distances, three stages
// depends on blfw_pkg
module blfw_dist #(
    parameter int MAX_DIM = blfw_pkg::MAX_DIM_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  blfw_pkg::cfg_t                        cfg,
    input  logic                                  in_valid,
    input  logic [2:0][blfw_pkg::IDX_W-1:0]       in_idx,
    input  blfw_pkg::cplx_t                       in_data,
    input  logic                                  down_en,
    output logic                                  up_en,
    output blfw_pkg::pipe_ctl_t                   out_ctl,
    output logic [blfw_pkg::DATA_W-1:0]           out_s,
    output blfw_pkg::cplx_t                       out_data
);
    import blfw_pkg::*;

    localparam int CMP_W = 18;

    logic [2:0][TM_W-1:0]   tm;
    logic [2:0][NORM_W-1:0] nrm;
    logic [2:0][IDX_W-1:0]  idx_c;
    logic [2:0][TM_W-1:0]   fold_dist;
    logic [2:0][T_W-1:0]    t_next;
    logic [2:0][T_W-1:0]    t1_reg;
    logic [2:0][63:0]       sq_full;
    logic [2:0][SQ_W-1:0]   sq_next;
    logic [2:0][SQ_W-1:0]   sq2_reg;
    logic                   sat_next;
    logic                   sat2_reg;
    logic [SQ_W+1:0]        sum;
    logic [DATA_W-1:0]      s3_reg;
    logic                   sat3_reg;
    logic                   v1_reg, v2_reg, v3_reg;
    logic                   en1, en2, en3;
    cplx_t                  d1_reg, d2_reg, d3_reg;

    assign tm  = {cfg.tm_z, cfg.tm_y, cfg.tm_x};
    assign nrm = {cfg.norm_z, cfg.norm_y, cfg.norm_x};

    assign en3   = !v3_reg || down_en;
    assign en2   = !v2_reg || en3;
    assign en1   = !v1_reg || en2;
    assign up_en = en1;

    // stage 1: clamp, fold and scale
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (CMP_W'(in_idx[a]) >= CMP_W'(MAX_DIM))
                idx_c[a] = IDX_W'(MAX_DIM - 1);
            else
                idx_c[a] = in_idx[a];
            if ({idx_c[a], 1'b0} > tm[a])
            begin
                if (tm[a] >= TM_W'(idx_c[a]))
                    fold_dist[a] = tm[a] - TM_W'(idx_c[a]);
                else
                    fold_dist[a] = TM_W'(idx_c[a]) - tm[a];
            end
            else
                fold_dist[a] = TM_W'(idx_c[a]);
            t_next[a] = T_W'(fold_dist[a]) * T_W'(nrm[a]);
        end
    end

    // stage 2: square in q.16
    always_comb
    begin
        sat_next = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (t1_reg[a][T_W-1:DATA_W] != '0)
                sat_next = 1'b1;
            sq_full[a] = 64'(t1_reg[a][DATA_W-1:0]) * 64'(t1_reg[a][DATA_W-1:0]);
            sq_next[a] = sq_full[a][63:16];
        end
    end

    // stage 3: sum
    assign sum = (SQ_W+2)'(sq2_reg[0]) + (SQ_W+2)'(sq2_reg[1]) + (SQ_W+2)'(sq2_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            t1_reg <= t_next;
            d1_reg <= in_data;
        end
        if (en2)
        begin
            sq2_reg  <= sq_next;
            sat2_reg <= sat_next;
            d2_reg   <= d1_reg;
        end
        if (en3)
        begin
            s3_reg   <= sum[DATA_W-1:0];
            sat3_reg <= sat2_reg || (sum[SQ_W+1:DATA_W] != '0);
            d3_reg   <= d2_reg;
        end
    end

    assign out_ctl.valid = v3_reg;
    assign out_ctl.sat   = sat3_reg;
    assign out_s         = s3_reg;
    assign out_data      = d3_reg;
endmodule

// ===== hdl/blfw_power.sv =====
// integer power of the summed square, one multiply per stage
// depends on blfw_pkg
module blfw_power (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [blfw_pkg::ORDER_W-1:0]   order,
    input  blfw_pkg::pipe_ctl_t            in_ctl,
    input  logic [blfw_pkg::DATA_W-1:0]    in_s,
    input  blfw_pkg::cplx_t                in_data,
    input  logic                           down_en,
    output logic                           up_en,
    output blfw_pkg::pipe_ctl_t            out_ctl,
    output logic [blfw_pkg::DATA_W-1:0]    out_p,
    output blfw_pkg::cplx_t                out_data
);
    import blfw_pkg::*;

    localparam int N = POW_STAGES;

    pipe_ctl_t         ctl_reg [N];
    logic [DATA_W-1:0] p_reg   [N];
    logic [DATA_W-1:0] s_reg   [N];
    cplx_t             d_reg   [N];

    pipe_ctl_t         ctl_in  [N];
    logic [DATA_W-1:0] p_in    [N];
    logic [DATA_W-1:0] s_in    [N];
    cplx_t             d_in    [N];
    logic [63:0]       prod    [N];
    logic              active  [N];
    logic [DATA_W-1:0] p_next  [N];
    logic              sat_next[N];
    logic [N-1:0]      en;

    always_comb
    begin
        ctl_in[0] = in_ctl;
        p_in[0]   = ONE_Q16;
        s_in[0]   = in_s;
        d_in[0]   = in_data;
        for (int k = 1; k < N; k++)
        begin
            ctl_in[k] = ctl_reg[k-1];
            p_in[k]   = p_reg[k-1];
            s_in[k]   = s_reg[k-1];
            d_in[k]   = d_reg[k-1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            prod[k]     = 64'(p_in[k]) * 64'(s_in[k]);
            active[k]   = !ctl_in[k].sat && (ORDER_W'(k) < order);
            p_next[k]   = active[k] ? prod[k][DATA_W+15:16] : p_in[k];
            sat_next[k] = ctl_in[k].sat || (active[k] && (prod[k][63:DATA_W+16] != '0));
        end
    end

    // a stage takes new data when empty or when the one after it moves on
    always_comb
    begin
        en[N-1] = !ctl_reg[N-1].valid || down_en;
        for (int k = N - 2; k >= 0; k--)
            en[k] = !ctl_reg[k].valid || en[k+1];
    end

    assign up_en = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
                ctl_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
                if (en[k])
                begin
                    ctl_reg[k].valid <= ctl_in[k].valid;
                    ctl_reg[k].sat   <= sat_next[k];
                end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
            if (en[k])
            begin
                p_reg[k] <= p_next[k];
                s_reg[k] <= s_in[k];
                d_reg[k] <= d_in[k];
            end
    end

    assign out_ctl  = ctl_reg[N-1];
    assign out_p    = p_reg[N-1];
    assign out_data = d_reg[N-1];
endmodule

// ===== hdl/blfw_recip.sv =====
// weight 1/(1+p) by restoring division, one quotient bit per stage
// depends on blfw_pkg
module blfw_recip (
    input  logic                           clk,
    input  logic                           rst_n,
    input  blfw_pkg::pipe_ctl_t            in_ctl,
    input  logic [blfw_pkg::DATA_W-1:0]    in_p,
    input  blfw_pkg::cplx_t                in_data,
    input  logic                           down_en,
    output logic                           up_en,
    output blfw_pkg::pipe_ctl_t            out_ctl,
    output logic [blfw_pkg::W_W-1:0]       out_w,
    output blfw_pkg::cplx_t                out_data
);
    import blfw_pkg::*;

    localparam int N    = DIV_STAGES;
    localparam int R_W  = DATA_W + 1;
    localparam int DS_W = R_W + N;

    pipe_ctl_t       ctl_reg [N];
    logic            unit_reg[N];
    logic [R_W-1:0]  r_reg   [N];
    logic [R_W-1:0]  dv_reg  [N];
    logic [W_W-1:0]  q_reg   [N];
    cplx_t           d_reg   [N];

    pipe_ctl_t       ctl_in  [N];
    logic            unit_in [N];
    logic [R_W-1:0]  r_in    [N];
    logic [R_W-1:0]  dv_in   [N];
    logic [W_W-1:0]  q_in    [N];
    cplx_t           d_in    [N];
    logic [DS_W-1:0] ds      [N];
    logic            take    [N];
    logic [R_W-1:0]  r_next  [N];
    logic [W_W-1:0]  q_next  [N];
    logic [N-1:0]    en;

    always_comb
    begin
        ctl_in[0]  = in_ctl;
        unit_in[0] = (in_p == '0);
        r_in[0]    = DIV_NUM;
        dv_in[0]   = R_W'(in_p) + R_W'(ONE_Q16);
        q_in[0]    = '0;
        d_in[0]    = in_data;
        for (int k = 1; k < N; k++)
        begin
            ctl_in[k]  = ctl_reg[k-1];
            unit_in[k] = unit_reg[k-1];
            r_in[k]    = r_reg[k-1];
            dv_in[k]   = dv_reg[k-1];
            q_in[k]    = q_reg[k-1];
            d_in[k]    = d_reg[k-1];
        end
    end

    // stage k decides quotient bit N-1-k
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            ds[k]     = DS_W'(dv_in[k]) << (N - 1 - k);
            take[k]   = DS_W'(r_in[k]) >= ds[k];
            r_next[k] = take[k] ? (r_in[k] - ds[k][R_W-1:0]) : r_in[k];
            q_next[k] = q_in[k];
            if (take[k])
                q_next[k][N-1-k] = 1'b1;
        end
    end

    always_comb
    begin
        en[N-1] = !ctl_reg[N-1].valid || down_en;
        for (int k = N - 2; k >= 0; k--)
            en[k] = !ctl_reg[k].valid || en[k+1];
    end

    assign up_en = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
                ctl_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
                if (en[k])
                    ctl_reg[k] <= ctl_in[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
            if (en[k])
            begin
                unit_reg[k] <= unit_in[k];
                r_reg[k]    <= r_next[k];
                dv_reg[k]   <= dv_in[k];
                q_reg[k]    <= q_next[k];
                d_reg[k]    <= d_in[k];
            end
    end

    // saturated power gives zero, zero power gives the largest weight
    always_comb
    begin
        if (ctl_reg[N-1].sat)
            out_w = '0;
        else if (unit_reg[N-1])
            out_w = W_MAX;
        else
            out_w = q_reg[N-1];
    end

    assign out_ctl  = ctl_reg[N-1];
    assign out_data = d_reg[N-1];
endmodule

// ===== hdl/butterworth_lowpass_freq_weight_unit.sv =====
// pipeline from request to result: 3 distance stages, 15 power
// stages (one multiplier each), 16 divider stages, one output multiply stage
// throughput one request per cycle; a full pipeline holds back requests only
// while the result is not taken; stalls ripple back through per-stage valids
// async active-low reset empties the pipeline and loads register defaults
// depends on blfw_pkg, blfw_in_if, blfw_out_if, blfw_dist, blfw_power, blfw_recip
`include "butterworth_lowpass_freq_weight_unit_defines.svh"

module butterworth_lowpass_freq_weight_unit #(
    parameter int MAX_DIM = blfw_pkg::MAX_DIM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [blfw_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [blfw_pkg::CFG_DATA_W-1:0] wr_data,
    blfw_in_if.sink                         sample,
    blfw_out_if.source                      result
);
    import blfw_pkg::*;

    // configuration registers; user writes them only while idle, not enforced here
    cfg_t                     cfg_reg;

    // distance section outputs
    pipe_ctl_t                dist_ctl;
    logic [DATA_W-1:0]        dist_s;
    cplx_t                    dist_data;
    logic                     dist_up_en;

    // power section outputs
    pipe_ctl_t                pow_ctl;
    logic [DATA_W-1:0]        pow_p;
    cplx_t                    pow_data;
    logic                     pow_up_en;

    // divider outputs
    pipe_ctl_t                div_ctl;
    logic [W_W-1:0]           div_w;
    cplx_t                    div_data;
    logic                     div_up_en;

    // output stage
    logic                     out_v_reg;
    logic signed [DATA_W-1:0] re_reg;
    logic signed [DATA_W-1:0] im_reg;
    logic                     out_en;
    logic signed [DATA_W+W_W:0] w_ext;
    logic signed [DATA_W+W_W:0] re_prod;
    logic signed [DATA_W+W_W:0] im_prod;
    cplx_t                    in_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TWICE_MID_X:  cfg_reg.tm_x   <= wr_data[TM_W-1:0];
                REG_TWICE_MID_Y:  cfg_reg.tm_y   <= wr_data[TM_W-1:0];
                REG_TWICE_MID_Z:  cfg_reg.tm_z   <= wr_data[TM_W-1:0];
                REG_NORM_X:       cfg_reg.norm_x <= wr_data[NORM_W-1:0];
                REG_NORM_Y:       cfg_reg.norm_y <= wr_data[NORM_W-1:0];
                REG_NORM_Z:       cfg_reg.norm_z <= wr_data[NORM_W-1:0];
                REG_FILTER_ORDER: cfg_reg.order  <= wr_data[ORDER_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_data.re = sample.real_in;
    assign in_data.im = sample.imag_in;

    // request accepted whenever the first distance stage can load
    assign sample.ready = dist_up_en;

    blfw_dist #(
        .MAX_DIM (MAX_DIM)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (sample.valid),
        .in_idx   ({sample.z_index, sample.y_index, sample.x_index}),
        .in_data  (in_data),
        .down_en  (pow_up_en),
        .up_en    (dist_up_en),
        .out_ctl  (dist_ctl),
        .out_s    (dist_s),
        .out_data (dist_data)
    );

    blfw_power u_power (
        .clk      (clk),
        .rst_n    (rst_n),
        .order    (cfg_reg.order),
        .in_ctl   (dist_ctl),
        .in_s     (dist_s),
        .in_data  (dist_data),
        .down_en  (div_up_en),
        .up_en    (pow_up_en),
        .out_ctl  (pow_ctl),
        .out_p    (pow_p),
        .out_data (pow_data)
    );

    blfw_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (pow_ctl),
        .in_p     (pow_p),
        .in_data  (pow_data),
        .down_en  (out_en),
        .up_en    (div_up_en),
        .out_ctl  (div_ctl),
        .out_w    (div_w),
        .out_data (div_data)
    );

    // weight times sample; the arithmetic shift floors toward minus infinity
    assign w_ext   = $signed((DATA_W+W_W+1)'(div_w));
    assign re_prod = (DATA_W+W_W+1)'(div_data.re) * w_ext;
    assign im_prod = (DATA_W+W_W+1)'(div_data.im) * w_ext;

    // output register parts the pipeline from the result channel
    assign out_en = !out_v_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_en)
            out_v_reg <= div_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            re_reg <= re_prod[DATA_W+15:16];
            im_reg <= im_prod[DATA_W+15:16];
        end
    end

    assign result.valid    = out_v_reg;
    assign result.real_out = re_reg;
    assign result.imag_out = im_reg;

    // requests are refused only when every stage is full behind a blocked result
    `BLFW_ASSERT_IMP(a_stall_only_when_blocked, clk, rst_n, !sample.ready, result.valid && !result.ready)
    // an order write lands in the register on the next cycle
    `BLFW_ASSERT_NXT(a_order_write, clk, rst_n, wr_en && (wr_index == REG_FILTER_ORDER), cfg_reg.order == $past(wr_data[ORDER_W-1:0]))
    // a new result only appears when the divider held a valid sample
    `BLFW_ASSERT_IMP(a_result_from_pipe, clk, rst_n, $rose(result.valid), $past(div_ctl.valid))
endmodule

// ===== sim/butterworth_lowpass_freq_weight_unit_tb.sv =====
// testbench for the butterworth low-pass frequency weighting unit
// self-checking: predicts each weighted sample and compares it with the result channel
// depends on blfw_pkg, blfw_in_if, blfw_out_if and butterworth_lowpass_freq_weight_unit
`timescale 1ns / 100ps

module butterworth_lowpass_freq_weight_unit_tb;
    import blfw_pkg::*;

    localparam int LATENCY   = 35;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [IDX_W-1:0]         xi;
        logic [IDX_W-1:0]         yi;
        logic [IDX_W-1:0]         zi;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } sample_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    blfw_in_if  sample ();
    blfw_out_if result ();

    butterworth_lowpass_freq_weight_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .sample   (sample),
        .result   (result)
    );

    // local copy of the register file
    logic [TM_W-1:0]    tm_x, tm_y, tm_z;
    logic [NORM_W-1:0]  nx, ny, nz;
    logic [ORDER_W-1:0] order;

    sample_t pending_samples[$];
    cplx_t   weighted_expect[$];

    bit     took;
    bit     fail;
    int     burst_left;
    int     gap_left;
    int     idle_cycles;
    int     ready_cnt;
    int     ready_mode;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // folded, scaled square of one axis distance in unsigned q.16
    function automatic longint unsigned axis_square(logic [IDX_W-1:0] idx,
            logic [TM_W-1:0] tm, logic [NORM_W-1:0] nrm, ref bit sat);
        longint unsigned fold_dist;
        longint unsigned t;
        fold_dist = idx;
        // indices past the fold point measure their distance from twice_mid
        if (2 * longint'(idx) > longint'(tm))
            fold_dist = (tm >= idx) ? longint'(tm) - longint'(idx) : longint'(idx) - longint'(tm);
        t = fold_dist * nrm;
        if (t >= 64'h1_0000_0000)
        begin
            sat = 1'b1;
            return 0;
        end
        return (t * t) >> 16;
    endfunction

    // butterworth weight 1/(1+s^order) in unsigned q0.16, zero on overflow
    function automatic longint unsigned butterworth_weight(sample_t s);
        bit sat;
        longint unsigned sum;
        longint unsigned pw;
        longint unsigned w;
        sat = 1'b0;
        sum = axis_square(s.xi, tm_x, nx, sat);
        sum += axis_square(s.yi, tm_y, ny, sat);
        sum += axis_square(s.zi, tm_z, nz, sat);
        if (sum >= 64'h1_0000_0000)
            sat = 1'b1;
        pw = 65536;
        for (int k = 0; k < order && !sat; k++)
        begin
            pw = (pw * sum) >> 16;
            if (pw >= 64'h1_0000_0000)
                sat = 1'b1;
        end
        if (sat)
            return 0;
        w = 64'h1_0000_0000 / (65536 + pw);
        // unit weight does not fit q0.16
        if (w > 65535)
            w = 65535;
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] scale(logic signed [DATA_W-1:0] v,
            longint unsigned w);
        longint prod;
        prod = longint'(v) * longint'(w);
        // arithmetic shift floors toward minus infinity
        return DATA_W'(prod >>> 16);
    endfunction

    function automatic cplx_t weighted_sample(sample_t s);
        longint unsigned w;
        cplx_t c;
        w = butterworth_weight(s);
        c.re = scale(s.re, w);
        c.im = scale(s.im, w);
        return c;
    endfunction

    task automatic write_reg(cfg_reg_t r, int unsigned v);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= r;
        wr_data  <= v[CFG_DATA_W-1:0];
        case (r)
            REG_TWICE_MID_X:  tm_x  = v[TM_W-1:0];
            REG_TWICE_MID_Y:  tm_y  = v[TM_W-1:0];
            REG_TWICE_MID_Z:  tm_z  = v[TM_W-1:0];
            REG_NORM_X:       nx    = v[NORM_W-1:0];
            REG_NORM_Y:       ny    = v[NORM_W-1:0];
            REG_NORM_Z:       nz    = v[NORM_W-1:0];
            REG_FILTER_ORDER: order = v[ORDER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(int unsigned mx, int unsigned my, int unsigned mz,
            int unsigned ax, int unsigned ay, int unsigned az, int unsigned ord);
        write_reg(REG_TWICE_MID_X, mx);
        write_reg(REG_TWICE_MID_Y, my);
        write_reg(REG_TWICE_MID_Z, mz);
        write_reg(REG_NORM_X, ax);
        write_reg(REG_NORM_Y, ay);
        write_reg(REG_NORM_Z, az);
        write_reg(REG_FILTER_ORDER, ord);
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // sender pauses until the pipeline has drained, then lets it settle
    task automatic drain();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || weighted_expect.size() != 0
               || sample.valid);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic queue_sample(int unsigned x, int unsigned y, int unsigned z,
            int unsigned re, int unsigned im);
        sample_t s;
        s.xi = x[IDX_W-1:0];
        s.yi = y[IDX_W-1:0];
        s.zi = z[IDX_W-1:0];
        s.re = re;
        s.im = im;
        pending_samples.push_back(s);
    endtask

    // indices mostly near the low or the high end so weights land mid range
    function automatic int unsigned pick_index();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1023);
            1: return $urandom_range(0, 64);
            2: return $urandom_range(960, 1023);
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    function automatic int unsigned pick_norm();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 24'hFFFFFF);
            1: return 0;
            2: return $urandom_range(1000, 20000);
            default: return $urandom_range(16, 1500);
        endcase
    endfunction

    function automatic int unsigned pick_mid();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 2047;
            2: return 1024;
            3: return 1;
            default: return $urandom_range(1, 2047);
        endcase
    endfunction

    // stimulus: directed corners, then random register settings and samples
    initial
    begin
        rst_n    = 1'b0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        sample.valid   = 1'b0;
        sample.x_index = '0;
        sample.y_index = '0;
        sample.z_index = '0;
        sample.real_in = '0;
        sample.imag_in = '0;
        result.ready   = 1'b0;
        tm_x = 11'd1024; tm_y = 11'd1024; tm_z = 11'd1;
        nx = '0; ny = '0; nz = '0;
        order = 4'd1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: zero norms give the saturated unit weight
        queue_sample(0, 0, 0, 32'h7FFFFFFF, 32'h80000000);
        queue_sample(1023, 1023, 1023, 32'h80000000, 32'h7FFFFFFF);
        queue_sample(5, 6, 7, 32'hFFFFFFFF, 32'h00000001);
        drain();

        // order zero: weight one half regardless of distance
        load_regs(1024, 1024, 1024, 700, 700, 700, 0);
        queue_sample(100, 900, 3, 32'h00010000, 32'hFFFF0000);
        queue_sample(1023, 0, 512, 32'hFFFFFFFF, 32'h7FFFFFFF);
        drain();

        // moderate cut-off: folding, weights near one half, order eight
        load_regs(1024, 1024, 1024, 655, 655, 655, 8);
        queue_sample(100, 0, 0, 32'h00010000, 32'hFFFF0000);
        queue_sample(924, 0, 0, 32'h12345678, 32'h87654321);
        queue_sample(512, 513, 0, 32'h7FFFFFFF, 32'h80000000);
        queue_sample(70, 70, 0, 32'h00010000, 32'h00010000);
        drain();

        // power overflow, zero fold point, index past fold
        load_regs(0, 2047, 1, 24'hFFFFFF, 1, 200, 2);
        queue_sample(1, 0, 0, 32'h7FFFFFFF, 32'h80000000);
        queue_sample(0, 1023, 0, 32'h00010000, 32'h00010000);
        queue_sample(0, 0, 1023, 32'hABCDEF01, 32'h10FEDCBA);
        queue_sample(0, 0, 1, 32'hFFFF0000, 32'h0000FFFF);
        queue_sample(0, 1023, 1, 32'h00000001, 32'hFFFFFFFF);
        drain();

        // small fold points on x and y: every index above one folds past twice_mid
        load_regs(1, 3, 2047, 40, 300, 24'h000100, 8);
        queue_sample(1023, 2, 1023, 32'h00020000, 32'hFFFE0000);
        queue_sample(0, 1023, 0, 32'h7FFFFFFF, 32'h80000000);
        queue_sample(512, 1, 1000, 32'h55555555, 32'hAAAAAAAA);
        drain();

        for (int ph = 0; ph < 11; ph++)
        begin
            load_regs(pick_mid(), pick_mid(), pick_mid(),
                      pick_norm(), pick_norm(), pick_norm(),
                      (ph == 0) ? 8 : (ph == 1) ? 0 : $urandom_range(0, 8));
            repeat (48)
                queue_sample(pick_index(), pick_index(), pick_index(),
                             $urandom(), $urandom());
            drain();
        end

        if (fail)
            $display("TB_ERROR");
        else
            $display("TB_OK");
        $finish;
    end

    // accept at the rising edge: predict the weighted sample
    always @(posedge clk)
    begin
        sample_t s;
        took = sample.valid && sample.ready;
        if (took)
        begin
            s.xi = sample.x_index;
            s.yi = sample.y_index;
            s.zi = sample.z_index;
            s.re = sample.real_in;
            s.im = sample.imag_in;
            weighted_expect.push_back(weighted_sample(s));
        end
    end

    // request driver: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        sample_t s;
        logic nv;
        if (rst_n && (!sample.valid || took))
        begin
            nv = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_samples.size() > 0)
            begin
                s = pending_samples.pop_front();
                sample.x_index <= s.xi;
                sample.y_index <= s.yi;
                sample.z_index <= s.zi;
                sample.real_in <= s.re;
                sample.imag_in <= s.im;
                nv = 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    // some bursts run straight into the next one
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
                else
                    burst_left--;
            end
            sample.valid <= nv;
        end
    end

    // result stall pattern: always ready, random, or periodic; a counter picks the mode anew
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            ready_cnt++;
            if (ready_cnt % 100 == 0)
                ready_mode = $urandom_range(0, 2);
            case (ready_mode)
                0: result.ready <= 1'b1;
                1: result.ready <= ($urandom_range(0, 1) == 1);
                default: result.ready <= (ready_cnt % 5 != 0) && (ready_cnt % 7 != 0);
            endcase
        end
    end

    // result monitor: compare against the oldest prediction
    always @(posedge clk)
    begin
        cplx_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (weighted_expect.size() == 0)
            begin
                $display("%0t: unexpected result re=%h im=%h", $time,
                         result.real_out, result.imag_out);
                fail = 1'b1;
            end
            else
            begin
                e = weighted_expect.pop_front();
                if (result.real_out !== e.re)
                begin
                    $display("%0t: real_out expected %h actual %h", $time, e.re,
                             result.real_out);
                    fail = 1'b1;
                end
                if (result.imag_out !== e.im)
                begin
                    $display("%0t: imag_out expected %h actual %h", $time, e.im,
                             result.imag_out);
                    fail = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
